@@ rtl/utr_pkg.sv @@
`timescale 1ns / 1ps

package utr_pkg;

    // encoding codes (6 and 7 fall back to ISO-8859-1)
    localparam logic [2:0] FMT_UTF8    = 3'd0;
    localparam logic [2:0] FMT_UTF16LE = 3'd1;
    localparam logic [2:0] FMT_UTF16BE = 3'd2;
    localparam logic [2:0] FMT_UTF32LE = 3'd3;
    localparam logic [2:0] FMT_UTF32BE = 3'd4;
    localparam logic [2:0] FMT_LATIN1  = 3'd5;

    // result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_LEAD   = 3'd1;
    localparam logic [2:0] ST_TRUNC      = 3'd2;
    localparam logic [2:0] ST_BAD_CP     = 3'd3;
    localparam logic [2:0] ST_LONE_LEAD  = 3'd4;
    localparam logic [2:0] ST_LONE_TRAIL = 3'd5;
    localparam logic [2:0] ST_UNENC      = 3'd6;
    localparam logic [2:0] ST_TAIL       = 3'd7;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_FMT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DST_FMT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRICT  = 2'd2;

    localparam int unsigned MAX_RES = 8;

    localparam logic [20:0] CP_REPL    = 21'h00FFFD;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;
    localparam logic [20:0] CP_SUPP    = 21'h010000;
    localparam logic [7:0]  LATIN1_SUB = 8'h3F;

    typedef struct packed {
        logic [2:0] src;
        logic [2:0] dst;
        logic       strict;
    } t_cfg;

    // one encoded code point or status: up to four words sharing flag and status
    typedef struct packed {
        logic [3:0][7:0] b;
        logic            vld;
        logic [2:0]      st;
        logic [2:0]      n;
    } t_evt;

    typedef struct packed {
        logic [7:0] ob;
        logic       vld;
        logic [2:0] st;
    } t_res;

    // all results of one source byte
    typedef struct packed {
        t_res [MAX_RES-1:0] ent;
        logic [3:0]         n;
    } t_run;

    function automatic logic cp_ok(input logic [20:0] cp);
        return (cp <= CP_MAX) && ((cp < 21'h00D800) || (cp > 21'h00DFFF));
    endfunction

    function automatic t_evt encode_evt(
        input logic [20:0] cp,
        input logic [2:0]  st,
        input logic [2:0]  df,
        input logic        strict,
        input logic        stat_only
    );
        t_evt        e;
        logic [19:0] c;
        logic [15:0] u0;
        logic [15:0] u1;
        e     = '0;
        c     = 20'(cp - CP_SUPP);
        u0    = cp[15:0];
        u1    = '0;
        e.vld = 1'b1;
        e.st  = st;
        if (stat_only) begin
            e.vld = 1'b0;
            e.n   = 3'd1;
        end else begin
            unique case (df)
                FMT_UTF8: begin
                    if (cp < 21'h80) begin
                        e.b[0] = cp[7:0];
                        e.n    = 3'd1;
                    end else if (cp < 21'h800) begin
                        e.b[0] = {3'b110, cp[10:6]};
                        e.b[1] = {2'b10, cp[5:0]};
                        e.n    = 3'd2;
                    end else if (cp < CP_SUPP) begin
                        e.b[0] = {4'b1110, cp[15:12]};
                        e.b[1] = {2'b10, cp[11:6]};
                        e.b[2] = {2'b10, cp[5:0]};
                        e.n    = 3'd3;
                    end else begin
                        e.b[0] = {5'b11110, cp[20:18]};
                        e.b[1] = {2'b10, cp[17:12]};
                        e.b[2] = {2'b10, cp[11:6]};
                        e.b[3] = {2'b10, cp[5:0]};
                        e.n    = 3'd4;
                    end
                end
                FMT_UTF16LE, FMT_UTF16BE: begin
                    if (cp >= CP_SUPP) begin
                        u0  = 16'hD800 | {6'b0, c[19:10]};
                        u1  = 16'hDC00 | {6'b0, c[9:0]};
                        e.n = 3'd4;
                    end else begin
                        e.n = 3'd2;
                    end
                    if (df == FMT_UTF16LE) begin
                        e.b[0] = u0[7:0];
                        e.b[1] = u0[15:8];
                        e.b[2] = u1[7:0];
                        e.b[3] = u1[15:8];
                    end else begin
                        e.b[0] = u0[15:8];
                        e.b[1] = u0[7:0];
                        e.b[2] = u1[15:8];
                        e.b[3] = u1[7:0];
                    end
                end
                FMT_UTF32LE: begin
                    e.b[0] = cp[7:0];
                    e.b[1] = cp[15:8];
                    e.b[2] = {3'b0, cp[20:16]};
                    e.b[3] = 8'h00;
                    e.n    = 3'd4;
                end
                FMT_UTF32BE: begin
                    e.b[0] = 8'h00;
                    e.b[1] = {3'b0, cp[20:16]};
                    e.b[2] = cp[15:8];
                    e.b[3] = cp[7:0];
                    e.n    = 3'd4;
                end
                default: begin
                    e.n = 3'd1;
                    if (cp > 21'h0000FF) begin
                        if (st != ST_OK) begin
                            e.b[0] = LATIN1_SUB;
                        end else if (strict) begin
                            e.vld = 1'b0;
                            e.st  = ST_UNENC;
                        end else begin
                            e.b[0] = LATIN1_SUB;
                            e.st   = ST_UNENC;
                        end
                    end else begin
                        e.b[0] = cp[7:0];
                    end
                end
            endcase
        end
        return e;
    endfunction

endpackage

@@ rtl/utr_decode.sv @@
`timescale 1ns / 1ps

// Decoder state plus the single-pass decode/encode of one source byte.
// o_run is combinational from the state and the offered byte; it is
// meaningful in the cycle the byte is accepted.
module utr_decode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  utr_pkg::t_cfg i_cfg,
    input  logic          i_clear,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    input  logic          i_eos,
    output utr_pkg::t_run o_run
);
    import utr_pkg::*;

    logic [23:0] r_unit, n_unit;
    logic [2:0]  r_cnt,  n_cnt;
    logic [1:0]  r_rem,  n_rem;
    logic [1:0]  r_tot,  n_tot;
    logic [14:0] r_part, n_part;
    logic [9:0]  r_held, n_held;
    logic        r_lp,   n_lp;

    logic [31:0] x_ub;
    logic [2:0]  x_cnt;
    logic [15:0] v16;
    logic [31:0] v32;
    logic        ld_ascii;
    logic [1:0]  ld_tot;
    logic [14:0] ld_part;
    logic        cont;
    logic [20:0] p;
    logic [20:0] minv;
    logic        is_lead;
    logic        is_trail;

    logic        a_en;
    logic [2:0]  a_st;
    logic        b_en;
    logic [20:0] b_cp;
    logic [2:0]  b_st;
    logic        b_fail;
    logic        tail;

    t_evt        a_evt;
    t_evt        b_evt;
    logic [3:0]  na;
    logic [3:0]  nb;
    logic [3:0]  ntot;

    always_comb begin
        x_ub     = {r_unit, i_byte};
        x_cnt    = r_cnt + 3'd1;
        v16      = (i_cfg.src == FMT_UTF16LE) ? {x_ub[7:0], x_ub[15:8]} : x_ub[15:0];
        v32      = (i_cfg.src == FMT_UTF32LE) ?
                   {x_ub[7:0], x_ub[15:8], x_ub[23:16], x_ub[31:24]} : x_ub;
        is_lead  = (v16[15:10] == 6'b110110);
        is_trail = (v16[15:10] == 6'b110111);
        cont     = (i_byte[7:6] == 2'b10);
        p        = {r_part, i_byte[5:0]};
        ld_ascii = ~i_byte[7];
        ld_tot   = 2'd0;
        ld_part  = '0;
        if (i_byte[7:5] == 3'b110) begin
            ld_tot  = 2'd1;
            ld_part = {10'b0, i_byte[4:0]};
        end else if (i_byte[7:4] == 4'b1110) begin
            ld_tot  = 2'd2;
            ld_part = {11'b0, i_byte[3:0]};
        end else if (i_byte[7:3] == 5'b11110) begin
            ld_tot  = 2'd3;
            ld_part = {12'b0, i_byte[2:0]};
        end
        unique case (r_tot)
            2'd1:    minv = 21'h000080;
            2'd2:    minv = 21'h000800;
            default: minv = CP_SUPP;
        endcase
    end

    always_comb begin
        n_unit = r_unit;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_tot  = r_tot;
        n_part = r_part;
        n_held = r_held;
        n_lp   = r_lp;
        a_en   = 1'b0;
        a_st   = ST_OK;
        b_en   = 1'b0;
        b_cp   = '0;
        b_st   = ST_OK;
        b_fail = 1'b0;
        unique case (i_cfg.src)
            FMT_UTF8: begin
                if (r_rem == 2'd0 || !cont) begin
                    // a byte that breaks a sequence restarts as a lead
                    if (r_rem != 2'd0) begin
                        a_en = 1'b1;
                        a_st = ST_TRUNC;
                    end
                    n_rem  = 2'd0;
                    n_tot  = 2'd0;
                    n_part = '0;
                    if (ld_ascii) begin
                        b_en = 1'b1;
                        b_cp = {13'b0, i_byte};
                    end else if (ld_tot == 2'd0) begin
                        b_en   = 1'b1;
                        b_fail = 1'b1;
                        b_st   = ST_BAD_LEAD;
                    end else begin
                        n_tot  = ld_tot;
                        n_rem  = ld_tot;
                        n_part = ld_part;
                    end
                end else begin
                    n_rem  = r_rem - 2'd1;
                    n_part = p[14:0];
                    if (r_rem == 2'd1) begin
                        n_tot  = 2'd0;
                        n_part = '0;
                        b_en   = 1'b1;
                        if (p < minv || !cp_ok(p)) begin
                            b_fail = 1'b1;
                            b_st   = ST_BAD_CP;
                        end else begin
                            b_cp = p;
                        end
                    end
                end
            end
            FMT_UTF16LE, FMT_UTF16BE: begin
                n_unit = x_ub[23:0];
                n_cnt  = x_cnt;
                if (x_cnt == 3'd2) begin
                    n_unit = '0;
                    n_cnt  = '0;
                    if (r_lp && is_trail) begin
                        n_lp   = 1'b0;
                        n_held = '0;
                        b_en   = 1'b1;
                        b_cp   = {1'b0, r_held, v16[9:0]} + CP_SUPP;
                    end else begin
                        if (r_lp) begin
                            a_en   = 1'b1;
                            a_st   = ST_LONE_LEAD;
                            n_lp   = 1'b0;
                            n_held = '0;
                        end
                        if (is_lead) begin
                            n_lp   = 1'b1;
                            n_held = v16[9:0];
                        end else if (is_trail) begin
                            b_en   = 1'b1;
                            b_fail = 1'b1;
                            b_st   = ST_LONE_TRAIL;
                        end else begin
                            b_en = 1'b1;
                            b_cp = {5'b0, v16};
                        end
                    end
                end
            end
            FMT_UTF32LE, FMT_UTF32BE: begin
                n_unit = x_ub[23:0];
                n_cnt  = x_cnt;
                if (x_cnt == 3'd4) begin
                    n_unit = '0;
                    n_cnt  = '0;
                    b_en   = 1'b1;
                    if (v32[31:21] != 11'b0 || !cp_ok(v32[20:0])) begin
                        b_fail = 1'b1;
                        b_st   = ST_BAD_CP;
                    end else begin
                        b_cp = v32[20:0];
                    end
                end
            end
            default: begin
                b_en = 1'b1;
                b_cp = {13'b0, i_byte};
            end
        endcase
        // end of stream: report and drop anything still pending
        tail = i_eos && (n_rem != 2'd0 || n_cnt != 3'd0 || n_lp);
        if (i_eos) begin
            n_unit = '0;
            n_cnt  = '0;
            n_rem  = '0;
            n_tot  = '0;
            n_part = '0;
            n_held = '0;
            n_lp   = 1'b0;
        end
    end

    always_comb begin
        a_evt = encode_evt(CP_REPL, a_st, i_cfg.dst, i_cfg.strict, i_cfg.strict);
        b_evt = encode_evt(b_fail ? CP_REPL : b_cp, b_st, i_cfg.dst, i_cfg.strict,
                           b_fail & i_cfg.strict);
        na    = a_en ? {1'b0, a_evt.n} : 4'd0;
        nb    = b_en ? {1'b0, b_evt.n} : 4'd0;
        ntot  = na + nb + {3'b0, tail};
        o_run.n = (ntot > 4'(MAX_RES)) ? 4'(MAX_RES) : ntot;
        for (int k = 0; k < MAX_RES; k++) begin
            logic [3:0] kk;
            logic [3:0] kb;
            kk = 4'(k);
            kb = kk - na;
            if (kk < na) begin
                o_run.ent[k] = '{ob: a_evt.b[kk[1:0]], vld: a_evt.vld, st: a_evt.st};
            end else if (kk < na + nb) begin
                o_run.ent[k] = '{ob: b_evt.b[kb[1:0]], vld: b_evt.vld, st: b_evt.st};
            end else begin
                o_run.ent[k] = '{ob: 8'h00, vld: 1'b0, st: ST_TAIL};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_unit <= '0;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_tot  <= '0;
            r_part <= '0;
            r_held <= '0;
            r_lp   <= 1'b0;
        end else if (i_accept) begin
            r_unit <= n_unit;
            r_cnt  <= n_cnt;
            r_rem  <= n_rem;
            r_tot  <= n_tot;
            r_part <= n_part;
            r_held <= n_held;
            r_lp   <= n_lp;
        end
    end

endmodule

@@ rtl/unicode_transcoder.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Handshake                   Payload
// s_axis   in   s_axis_tvalid/tready        tdata = source byte, tlast = end of stream
// m_axis   out  m_axis_tvalid/tready        tdata = destination byte, tuser = flag+status,
//                                           tlast = last word caused by one source byte
// cfg      in   i_cfg_we (no wait)          i_cfg_idx, i_cfg_data
//
// Cycles: a byte is decoded and encoded in the cycle it is taken; its 0 to 8 words
//   go to the output run register (pending run register if that is busy) and leave
//   one per cycle while m_axis_tready is high; one-word bytes run at one byte a cycle.
// Stalls: tready drops only while the pending run is full; one byte's run can wait there.
// Reset: synchronous, active low; clears decoder state, config (UTF-8 to UTF-8,
//   lenient) and both run registers. A config write to a defined index clears decoder state.
module unicode_transcoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // cfg write port
    input  logic                           i_cfg_we,
    input  logic [utr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [2:0]                     i_cfg_data,
    // source bytes
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] in_byte
    input  logic                           s_axis_tlast,   // end_of_stream
    // destination words
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,   // [7:0] out_byte
    output logic [3:0]                     m_axis_tuser,   // [0] byte_valid, [3:1] status
    output logic                           m_axis_tlast    // run_last
);
    import utr_pkg::*;

    t_cfg       r_cfg;
    logic       cfg_clear;
    logic       accept;
    t_run       dec_run;
    logic       dec_words;

    t_run       r_pend;
    logic       r_pend_vld;
    t_run       r_run;
    logic       r_run_vld;
    logic [2:0] r_idx;

    logic       out_fire;
    logic       out_last;
    logic       run_free;
    t_res       cur;

    // any write to a defined register flushes partial sequences
    assign cfg_clear = i_cfg_we && (i_cfg_idx == REG_SRC_FMT || i_cfg_idx == REG_DST_FMT ||
                                    i_cfg_idx == REG_STRICT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SRC_FMT: r_cfg.src    <= i_cfg_data;
                REG_DST_FMT: r_cfg.dst    <= i_cfg_data;
                REG_STRICT:  r_cfg.strict <= i_cfg_data[0];
                default:     ;
            endcase
        end
    end

    assign s_axis_tready = ~r_pend_vld;
    assign accept        = s_axis_tvalid & s_axis_tready;

    utr_decode u_dec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_clear  (cfg_clear),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_eos    (s_axis_tlast),
        .o_run    (dec_run)
    );

    assign dec_words = (dec_run.n != 4'd0);

    assign out_fire = r_run_vld & m_axis_tready;
    assign out_last = ({1'b0, r_idx} == (r_run.n - 4'd1));
    // output run register can take a new run this cycle
    assign run_free = ~r_run_vld | (out_fire & out_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
            r_run_vld  <= 1'b0;
            r_idx      <= '0;
        end else begin
            // a fresh run skips the pending register when the output run frees up
            r_pend_vld <= r_pend_vld ? ~run_free : (accept & dec_words & ~run_free);
            if (run_free) begin
                r_run_vld <= r_pend_vld | (accept & dec_words);
                r_idx     <= '0;
            end else if (out_fire) begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !run_free) begin
            r_pend <= dec_run;
        end
        if (run_free) begin
            r_run <= r_pend_vld ? r_pend : dec_run;
        end
    end

    assign cur           = r_run.ent[r_idx];
    assign m_axis_tvalid = r_run_vld;
    assign m_axis_tdata  = cur.ob;
    assign m_axis_tuser  = {cur.st, cur.vld};
    assign m_axis_tlast  = out_last;

endmodule

@@ rtl/utr_check.sv @@
`timescale 1ns / 1ps

module utr_check (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_we,
    input logic [utr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input logic [2:0]                    i_cfg_data,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [7:0]                    s_axis_tdata,
    input logic                          s_axis_tlast,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [7:0]                    m_axis_tdata,
    input logic [3:0]                    m_axis_tuser,
    input logic                          m_axis_tlast
);
    import utr_pkg::*;

    // a stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // both run registers empty after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("run registers not cleared by reset");

    // status-only words carry a zero byte
    a_stat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'h00)
        else $error("status-only word with nonzero byte");

    // incomplete tail is never a data byte, and always closes its run
    a_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[3:1] == ST_TAIL |-> !m_axis_tuser[0] && m_axis_tlast)
        else $error("bad incomplete-tail word");

    // an unencodable data byte is always the Latin-1 substitute
    a_unenc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[3:1] == ST_UNENC |->
            m_axis_tdata == LATIN1_SUB)
        else $error("unencodable word is not the substitute");

endmodule

bind unicode_transcoder utr_check u_utr_check (.*);
